[design/splitmix64_random_source_defines.svh]
// ----------------------------------------------------------------------------
// SplitMix64 random source assertion macros
// Shared concurrent assertion forms for the design.
// ----------------------------------------------------------------------------
`ifndef SPLITMIX64_RANDOM_SOURCE_DEFINES_SVH
`define SPLITMIX64_RANDOM_SOURCE_DEFINES_SVH

// implication checked every clock, off during reset
`define SM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define SM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/sm64_pkg.sv]
// ----------------------------------------------------------------------------
// SplitMix64 package
// Command codes, constants and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sm64_pkg;

   typedef enum logic [1:0] {
      CMD_RAW   = 2'd0,
      CMD_BOUND = 2'd1,
      CMD_BOOL  = 2'd2,
      CMD_REAL  = 2'd3
   } cmd_type;

   localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] bound;
   } req_type;

endpackage

[design/sm64_queue.sv]
// ----------------------------------------------------------------------------
// SplitMix64 request queue
// Two-entry FIFO between the request front and the generator back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm64_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sm64_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output sm64_pkg::req_type pop_data
);

   sm64_pkg::req_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end

endmodule

[design/sm64_divider.sv]
// ----------------------------------------------------------------------------
// SplitMix64 remainder unit
// Radix-2 restoring remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm64_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] remainder
);

   logic [63:0] num_ff;
   logic [63:0] div_ff;
   logic [64:0] rem_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [64:0] shifted;
   logic [64:0] diff;

   assign shifted   = {rem_ff[63:0], num_ff[63]};
   assign diff      = shifted - {1'b0, div_ff};
   assign done      = done_ff;
   assign remainder = rem_ff[63:0];

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[62:0], 1'b0};
         rem_ff <= diff[64] ? shifted : diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

[design/sm64_engine.sv]
// ----------------------------------------------------------------------------
// SplitMix64 generator back end
// Advances the state, mixes over registered multiply steps, formats results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm64_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [63:0]       csr_wdata,
   input  logic              q_empty,
   input  sm64_pkg::req_type q_data,
   output logic              q_pop,
   output logic              busy,
   output logic [64:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MIX1, ST_MUL1, ST_MIX2, ST_MUL2, ST_FIN, ST_NORM, ST_DIV, ST_OUT
   } state_type;

   state_type         state_ff;
   logic [63:0]       gen_ff;
   logic [63:0]       z_ff;
   sm64_pkg::req_type req_ff;
   logic [63:0]       value_ff;
   logic              flag_ff;
   logic              rsp_valid_ff;
   logic [5:0]        top_ff;
   logic [52:0]       mant_ff;
   logic [1:0]        mstep_ff;
   logic [63:0]       acc_ff;
   logic              div_start;
   logic              div_done;
   logic [63:0]       div_rem;
   logic [63:0]       mul_c;
   logic [31:0]       mul_x;
   logic [31:0]       mul_y;
   logic [63:0]       mul_p;
   logic [63:0]       word_in;
   logic [63:0]       gen_in;

   // low 64 bits of z * c from three 32x32 partial products, one per cycle
   assign mul_c   = (state_ff == ST_MUL1) ? sm64_pkg::MIX_MUL_A : sm64_pkg::MIX_MUL_B;
   assign mul_x   = (mstep_ff == 2'd2) ? z_ff[63:32] : z_ff[31:0];
   assign mul_y   = (mstep_ff == 2'd1) ? mul_c[63:32] : mul_c[31:0];
   assign mul_p   = 64'(mul_x) * 64'(mul_y);
   assign word_in = z_ff ^ (z_ff >> 31);
   assign gen_in  = gen_ff + sm64_pkg::GOLDEN_STEP;
   assign q_pop   = (state_ff == ST_IDLE) && !q_empty && !csr_we && !rsp_valid_ff;
   assign busy    = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign div_start = (state_ff == ST_FIN) && (req_ff.cmd == sm64_pkg::CMD_BOUND)
                      && !req_ff.bound[63] && (req_ff.bound != 64'd0);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {flag_ff, value_ff};

   sm64_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  ({1'b0, word_in[63:1]}),
      .divisor   (req_ff.bound),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= 64'd1;
         rsp_valid_ff <= 1'b0;
         mstep_ff     <= 2'd0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            gen_ff <= (csr_wdata == 64'd0) ? 64'd1 : csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  req_ff   <= q_data;
                  gen_ff   <= gen_in;
                  z_ff     <= gen_in;
                  mstep_ff <= 2'd0;
                  state_ff <= ST_MIX1;
               end
            end
            ST_MIX1: begin
               z_ff     <= z_ff ^ (z_ff >> 30);
               state_ff <= ST_MUL1;
            end
            ST_MIX2: begin
               z_ff     <= z_ff ^ (z_ff >> 27);
               state_ff <= ST_MUL2;
            end
            ST_MUL1, ST_MUL2: begin
               case (mstep_ff)
                  2'd0: begin
                     acc_ff   <= mul_p;
                     mstep_ff <= 2'd1;
                  end
                  2'd1: begin
                     acc_ff[63:32] <= acc_ff[63:32] + mul_p[31:0];
                     mstep_ff      <= 2'd2;
                  end
                  default: begin
                     z_ff     <= {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
                     mstep_ff <= 2'd0;
                     state_ff <= (state_ff == ST_MUL1) ? ST_MIX2 : ST_FIN;
                  end
               endcase
            end
            ST_FIN: begin
               state_ff <= ST_OUT;
               value_ff <= word_in;
               flag_ff  <= 1'b0;
               case (req_ff.cmd)
                  sm64_pkg::CMD_RAW: ;
                  sm64_pkg::CMD_BOUND: begin
                     if (div_start) begin
                        state_ff <= ST_DIV;
                     end
                  end
                  sm64_pkg::CMD_BOOL: begin
                     value_ff <= 64'd0;
                     flag_ff  <= ~(z_ff[0] ^ z_ff[31]);
                  end
                  sm64_pkg::CMD_REAL: begin
                     mant_ff  <= 53'(word_in >> 11);
                     top_ff   <= 6'd52;
                     state_ff <= ST_NORM;
                  end
                  default: ;
               endcase
            end
            ST_NORM: begin
               if (mant_ff == 53'd0) begin
                  value_ff <= 64'd0;
                  state_ff <= ST_OUT;
               end else if (mant_ff[52]) begin
                  value_ff <= {1'b0, 11'(top_ff) + 11'd970, mant_ff[51:0]};
                  state_ff <= ST_OUT;
               end else if (mant_ff[52:45] == 8'd0) begin
                  mant_ff <= mant_ff << 8;
                  top_ff  <= top_ff - 6'd8;
               end else begin
                  mant_ff <= mant_ff << 1;
                  top_ff  <= top_ff - 6'd1;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  value_ff <= div_rem;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[design/splitmix64_random_source.sv]
// ----------------------------------------------------------------------------
// SplitMix64 random source
// channel   dir  payload
// req       in   tdata {bound, command}, 66 bits padded to 72
// rsp       out  tdata {flag, value}, 65 bits padded to 72
// csr       in   seed write, 64 bits
// Raw and boolean items pass the mix and multiply states to the response;
// each mix multiply forms three 32x32 partial products, one per cycle.
// Real items also pass the normalize shift loop and bounded items the 64-step
// remainder unit. Reset is synchronous and sets the state to one.
// A two-entry request queue decouples the front from the generator; a held
// result keeps the back end from taking the next request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "splitmix64_random_source_defines.svh"

module splitmix64_random_source (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [1:0] command, [65:2] bound
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [63:0] value, [64] flag
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);

   sm64_pkg::req_type push_data;
   sm64_pkg::req_type q_data;
   logic              q_full, q_empty, q_pop, busy;
   logic [64:0]       rsp_bits;

   assign push_data.cmd   = sm64_pkg::cmd_type'(req_tdata[1:0]);
   assign push_data.bound = req_tdata[65:2];
   assign req_tready      = !q_full;
   assign rsp_tdata       = {7'd0, rsp_bits};

   sm64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   sm64_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .busy       (busy),
      .rsp_tdata  (rsp_bits),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   `SM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SM_ASSERT_IMPL(a_flag_zero_val, clock, reset, rsp_tvalid && rsp_tdata[64], rsp_tdata[63:0] == 64'd0)
   `SM_ASSERT_IMPL(a_pop_busy, clock, reset, q_pop, !q_empty)
   `SM_ASSERT_IMPL(a_csr_idle, clock, reset, csr_we, !busy && q_empty)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// SplitMix64 random source testbench
// Drives request and seed-register transfers into the generator. It predicts
// every response from a local copy of the generator state or a typed-in value
// and compares each response field by field. The run covers several seeds and
// random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      sm64_pkg::cmd_type cmd;
      logic [63:0]       bound;
      bit                known;
      logic [63:0]       value;
      logic              flag;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic [63:0] csr_wdata;

   logic [63:0]  model_state;
   logic [64:0]  pending_rsp[$];
   stim_row_type dir_rows[$];
   int           errors;
   int           cycles;
   int           rsp_count;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           hold_off;

   splitmix64_random_source dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   function automatic logic [63:0] real_bits(logic [63:0] m);
      int          top;
      logic [63:0] frac;
      logic [63:0] expo;
      top = 0;
      if (m == 64'd0) begin
         return 64'd0;
      end
      for (int i = 0; i < 53; i++) begin
         if (m[i]) begin
            top = i;
         end
      end
      frac = (m << (52 - top)) & 64'h000f_ffff_ffff_ffff;
      expo = 64'(top + 970);
      return (expo << 52) | frac;
   endfunction

   // advance the local state and return the {flag, value} response
   function automatic logic [64:0] next_response(sm64_pkg::cmd_type cmd,
                                                 logic [63:0] bound);
      logic [63:0] z;
      logic [63:0] v;
      logic        f;
      model_state = model_state + sm64_pkg::GOLDEN_STEP;
      z = model_state;
      z = (z ^ (z >> 30)) * sm64_pkg::MIX_MUL_A;
      z = (z ^ (z >> 27)) * sm64_pkg::MIX_MUL_B;
      z = z ^ (z >> 31);
      v = 64'd0;
      f = 1'b0;
      case (cmd)
         sm64_pkg::CMD_RAW: v = z;
         sm64_pkg::CMD_BOUND: begin
            if (bound == 64'd0 || bound[63]) v = z;
            else v = (z >> 1) % bound;
         end
         sm64_pkg::CMD_BOOL: f = ~z[0];
         default: v = real_bits(z >> 11);
      endcase
      return {f, v};
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stall plus optional long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // check each response transfer
   always @(posedge clock) begin
      logic [64:0] exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %h", $time, rsp_tdata[64:0]);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_tdata[63:0] !== exp_rsp[63:0]) begin
               errors++;
               $display("%0t: value expected %h actual %h", $time, exp_rsp[63:0],
                        rsp_tdata[63:0]);
            end
            if (rsp_tdata[64] !== exp_rsp[64]) begin
               errors++;
               $display("%0t: flag expected %b actual %b", $time, exp_rsp[64],
                        rsp_tdata[64]);
            end
         end
      end
   end

   task automatic send_req(sm64_pkg::cmd_type cmd, logic [63:0] bound, bit known,
                           logic [63:0] kval, logic kflag);
      logic [64:0] pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, bound, cmd};
      do @(posedge clock); while (!req_tready);
      pred = next_response(cmd, bound);
      if (known) begin
         pending_rsp.push_back({kflag, kval});
      end else begin
         pending_rsp.push_back(pred);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(negedge clock);
      end
      repeat (100) @(negedge clock);
   endtask

   task automatic write_seed(logic [63:0] s);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= s;
      @(negedge clock);
      csr_we    <= 1'b0;
      model_state = (s == 64'd0) ? 64'd1 : s;
   endtask

   task automatic random_items(int n);
      sm64_pkg::cmd_type c;
      logic [63:0]       b;
      for (int i = 0; i < n; i++) begin
         c = sm64_pkg::cmd_type'($urandom_range(3));
         case ($urandom_range(5))
            0: b = {$urandom, $urandom};
            1: b = 64'($urandom_range(20));
            2: b = {1'b1, 31'($urandom), $urandom};
            3: b = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(3));
            default: b = {32'd0, $urandom};
         endcase
         send_req(c, b, 1'b0, 64'd0, 1'b0);
      end
   endtask

   function automatic void add_row(sm64_pkg::cmd_type c, logic [63:0] b, bit k,
                                   logic [63:0] v, logic f);
      stim_row_type r;
      r.cmd = c; r.bound = b; r.known = k; r.value = v; r.flag = f;
      dir_rows.push_back(r);
   endfunction

   initial begin
      errors = 0; rsp_count = 0; hold_off = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      req_tvalid = 1'b0; req_tdata = '0; csr_we = 1'b0; csr_wdata = '0;
      model_state = 64'd1;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first word from state one is typed in directly
      add_row(sm64_pkg::CMD_RAW, 64'd0, 1'b1, 64'h910a2dec89025cc1, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'd0, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'h8000_0000_0000_0000, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'hffff_ffff_ffff_ffff, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'd1, 1'b1, 64'd0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'd2, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'h7fff_ffff_ffff_ffff, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'h5555_5555_aaaa_aaaa, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOOL, 64'hffff_ffff_ffff_ffff, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOOL, 64'd0, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_REAL, 64'd0, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_REAL, 64'hffff_ffff_ffff_ffff, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_RAW, 64'hffff_ffff_ffff_ffff, 1'b0, '0, 1'b0);
      add_row(sm64_pkg::CMD_BOUND, 64'd3, 1'b0, '0, 1'b0);
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].cmd, dir_rows[i].bound, dir_rows[i].known,
                  dir_rows[i].value, dir_rows[i].flag);
      end

      // zero seed stores one: same first word again
      write_seed(64'd0);
      send_req(sm64_pkg::CMD_RAW, 64'd0, 1'b1, 64'h910a2dec89025cc1, 1'b0);
      write_seed(64'hffff_ffff_ffff_ffff);
      random_items(6);
      // state that mixes to a word of zero gives the real +0.0
      write_seed(64'd0 - sm64_pkg::GOLDEN_STEP);
      send_req(sm64_pkg::CMD_REAL, 64'd5, 1'b1, 64'd0, 1'b0);
      send_req(sm64_pkg::CMD_BOOL, 64'd5, 1'b0, '0, 1'b0);
      write_seed(64'h8000_0000_0000_0000);
      random_items(6);
      write_seed(64'h7fff_ffff_ffff_ffff);
      random_items(6);

      write_seed({$urandom, $urandom});
      random_items(150);
      send_idle_pct = 62;
      write_seed({$urandom, $urandom});
      random_items(150);
      send_idle_pct = 0; recv_stall_pct = 62;
      write_seed({$urandom, $urandom});
      random_items(150);
      send_idle_pct = 22; recv_stall_pct = 22;
      write_seed({$urandom, $urandom});
      random_items(150);

      // long receiver hold-off while requests keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      drain();
      hold_off = 600;
      random_items(20);
      drain();
      random_items(100);

      drain();
      $display("covered %0d responses over seeds incl. zero, extremes and random",
               rsp_count);
      $display("commands raw/bounded/bool/real, all idle phases and a long stall");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+design
design/sm64_pkg.sv
design/sm64_queue.sv
design/sm64_divider.sv
design/sm64_engine.sv
design/splitmix64_random_source.sv
tb/tb.sv
